// ----- design/tdf_pkg.sv -----
// ----------------------------------------------------------------------------
// tdf_pkg
// Shared types and constants for the trial division factorizer: the status
// bundle from the iterative divider and the fixed starting values.
// ----------------------------------------------------------------------------
package tdf_pkg;

  // status from the shared divider to the sequencer
  typedef struct packed {
    logic done;   // quotient and remainder valid this cycle
    logic exact;  // remainder is zero
  } tdf_div_status_t;

  // first candidate divisor and its square
  localparam int unsigned FirstDivisor = 2;
  localparam int unsigned FirstSquare  = 4;

endpackage

// ----- design/tdf_div.sv -----
// ----------------------------------------------------------------------------
// tdf_div
// Iterative restoring divider, one quotient bit per cycle. Done is high once
// the division completes, with quotient and exactness.
// ----------------------------------------------------------------------------
module tdf_div #(
  parameter int unsigned DIVIDEND_BITS = 31,
  parameter int unsigned DIVISOR_BITS  = 17
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [DIVIDEND_BITS-1:0]    dividend_i,
  input  logic [DIVISOR_BITS-1:0]     divisor_i,
  output logic [DIVIDEND_BITS-1:0]    quotient_o,
  output tdf_pkg::tdf_div_status_t    status_o
);
  import tdf_pkg::*;

  localparam int unsigned CntBits = $clog2(DIVIDEND_BITS + 1);

  logic [DIVIDEND_BITS-1:0] shift_q, shift_d;
  logic [DIVISOR_BITS-1:0]  rem_q, rem_d;
  logic [DIVISOR_BITS-1:0]  dsor_q, dsor_d;
  logic [CntBits-1:0]       cnt_q, cnt_d;
  logic                     run_q, run_d;
  logic [DIVISOR_BITS:0]    trial;
  logic [DIVISOR_BITS:0]    diff;
  logic                     fits;

  // one restoring step: shift in next dividend bit and try to subtract
  assign trial = {rem_q, shift_q[DIVIDEND_BITS-1]};
  assign fits  = trial >= {1'b0, dsor_q};
  assign diff  = trial - {1'b0, dsor_q};

  always_comb begin
    shift_d = shift_q;
    rem_d   = rem_q;
    dsor_d  = dsor_q;
    cnt_d   = cnt_q;
    run_d   = run_q;
    if (start_i) begin
      shift_d = dividend_i;
      rem_d   = '0;
      dsor_d  = divisor_i;
      cnt_d   = CntBits'(DIVIDEND_BITS);
      run_d   = 1'b1;
    end else if (run_q) begin
      rem_d   = fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
      shift_d = {shift_q[DIVIDEND_BITS-2:0], fits};
      cnt_d   = cnt_q - CntBits'(1);
      run_d   = (cnt_q != CntBits'(1));
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
    dsor_q  <= dsor_d;
  end

  // done registered together with the last step's result
  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= run_q && !start_i && (cnt_q == CntBits'(1));
    end
  end

  assign quotient_o     = shift_q;
  assign status_o.done  = done_q;
  assign status_o.exact = (rem_q == '0);

endmodule

// ----- design/trial_division_factorizer.sv -----
// ----------------------------------------------------------------------------
// trial_division_factorizer
// Emits the prime factors of one request in ascending order, with repeats.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low. Each factor is
// shown for exactly one cycle with result_valid_o high, in ascending order,
// with last_o on the final one; the receiver cannot stall and must take each
// result in the cycle it is shown. Inputs 0 and 1 give one result with
// is_empty_o and last_o set in the cycle after the request, and busy_o stays
// low for them. Every candidate divisor d with d*d <= value is tried (stopping
// early once the cofactor is 1), and each trial is a bit-serial division in
// the shared divider, and a divisor that divides is tried once more after each
// division. busy_o drops in the cycle the last result is shown, so the next
// request can be taken in that cycle.
// ----------------------------------------------------------------------------
module trial_division_factorizer #(
  parameter int unsigned VALUE_BITS = 31
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  result_valid_o,
  output logic [VALUE_BITS-1:0] factor_o,
  output logic                  is_empty_o,
  output logic                  last_o
);
  import tdf_pkg::*;

  localparam int unsigned DivBits = (VALUE_BITS + 1) / 2 + 1;
  localparam int unsigned SqBits  = VALUE_BITS + 1;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StTest = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [VALUE_BITS-1:0] original_q, original_d;
  logic [VALUE_BITS-1:0] remaining_q, remaining_d;
  logic [DivBits-1:0]    divisor_q, divisor_d;
  logic [SqBits-1:0]     square_q, square_d;
  logic                  div_start_q, div_start_d;
  logic                  res_valid_q, res_valid_d;
  logic [VALUE_BITS-1:0] res_factor_q, res_factor_d;
  logic                  res_empty_q, res_empty_d;
  logic                  res_last_q, res_last_d;

  logic [VALUE_BITS-1:0] quotient;
  tdf_div_status_t       div_status;
  logic                  quot_is_one;

  // shared iterative divider: remaining / divisor
  tdf_div #(
    .DIVIDEND_BITS(VALUE_BITS),
    .DIVISOR_BITS (DivBits)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start_q),
    .dividend_i(remaining_q),
    .divisor_i (divisor_q),
    .quotient_o(quotient),
    .status_o  (div_status)
  );

  assign quot_is_one = (quotient == VALUE_BITS'(1));

  // sequencer
  always_comb begin
    state_d      = state_q;
    original_d   = original_q;
    remaining_d  = remaining_q;
    divisor_d    = divisor_q;
    square_d     = square_q;
    div_start_d  = 1'b0;
    res_valid_d  = 1'b0;
    res_factor_d = res_factor_q;
    res_empty_d  = res_empty_q;
    res_last_d   = res_last_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          original_d  = value_i;
          remaining_d = value_i;
          divisor_d   = DivBits'(FirstDivisor);
          square_d    = SqBits'(FirstSquare);
          if (value_i < VALUE_BITS'(2)) begin
            // no factors: single empty result
            res_valid_d  = 1'b1;
            res_factor_d = '0;
            res_empty_d  = 1'b1;
            res_last_d   = 1'b1;
          end else begin
            state_d = StTest;
          end
        end
      end
      StTest: begin
        if ((square_q <= {1'b0, original_q}) && (remaining_q > VALUE_BITS'(1))) begin
          div_start_d = 1'b1;
          state_d     = StDiv;
        end else begin
          // leftover cofactor is prime and closes the run
          res_valid_d  = 1'b1;
          res_factor_d = remaining_q;
          res_empty_d  = 1'b0;
          res_last_d   = 1'b1;
          remaining_d  = VALUE_BITS'(1);
          state_d      = StIdle;
        end
      end
      StDiv: begin
        if (div_status.done) begin
          if (div_status.exact) begin
            // divisor divides: emit it and divide it out
            remaining_d  = quotient;
            res_valid_d  = 1'b1;
            res_factor_d = VALUE_BITS'(divisor_q);
            res_empty_d  = 1'b0;
            res_last_d   = quot_is_one;
            state_d      = quot_is_one ? StIdle : StTest;
          end else begin
            // next candidate, (d+1)^2 = d^2 + 2d + 1
            divisor_d = divisor_q + DivBits'(1);
            square_d  = square_q + SqBits'({divisor_q, 1'b1});
            state_d   = StTest;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      div_start_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_start_q <= div_start_d;
      res_valid_q <= res_valid_d;
    end
  end

  // working and result payload registers
  always_ff @(posedge clk_i) begin
    original_q   <= original_d;
    remaining_q  <= remaining_d;
    divisor_q    <= divisor_d;
    square_q     <= square_d;
    res_factor_q <= res_factor_d;
    res_empty_q  <= res_empty_d;
    res_last_q   <= res_last_d;
  end

  assign busy_o         = (state_q != StIdle);
  assign result_valid_o = res_valid_q;
  assign factor_o       = res_factor_q;
  assign is_empty_o     = res_empty_q;
  assign last_o         = res_last_q;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for trial_division_factorizer. Requests are sent through
// the start/busy handshake, and each request's prime factors are predicted in
// the bench. Every strobed result is compared field by field with the oldest
// predicted factor. Directed values cover the empty inputs, exact squares,
// long runs and the field extremes. Random values are mostly smooth numbers,
// so that large inputs finish quickly, plus small and medium values that mostly
// end with a prime cofactor.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned ValueBits = 31;
  localparam int unsigned MaxCycles = 25_000_000;

  typedef logic [ValueBits-1:0] value_t;

  // one predicted result of a request
  typedef struct {
    value_t factor;
    logic   is_empty;
    logic   last;
  } factor_rec_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start_i = 1'b0;
  value_t value_i = '0;
  logic   busy_o;
  logic   result_valid_o;
  value_t factor_o;
  logic   is_empty_o;
  logic   last_o;

  factor_rec_t expected_factors_q[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          idle_off = 1'b0;

  trial_division_factorizer #(
    .VALUE_BITS(ValueBits)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .value_i       (value_i),
    .result_valid_o(result_valid_o),
    .factor_o      (factor_o),
    .is_empty_o    (is_empty_o),
    .last_o        (last_o)
  );

  // clock
  always #4 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MaxCycles) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // prime factors of one value, ascending, with repeats
  function automatic void predict_factorization(input value_t v);
    value_t      factors[$];
    longint      rem;
    longint      d;
    factor_rec_t rec;
    if (v < 2) begin
      rec.factor   = '0;
      rec.is_empty = 1'b1;
      rec.last     = 1'b1;
      expected_factors_q.insert(expected_factors_q.size(), rec);
      return;
    end
    rem = longint'(v);
    for (d = 2; d * d <= rem_limit(v) && rem > 1; d++) begin
      while (rem % d == 0) begin
        rem = rem / d;
        factors.insert(factors.size(), value_t'(d));
      end
    end
    // leftover cofactor is prime
    if (rem > 1) factors.insert(factors.size(), value_t'(rem));
    foreach (factors[i]) begin
      rec.factor   = factors[i];
      rec.is_empty = 1'b0;
      rec.last     = (i == factors.size() - 1);
      expected_factors_q.insert(expected_factors_q.size(), rec);
    end
  endfunction

  // original value widened for the divisor bound
  function automatic longint rem_limit(input value_t v);
    return longint'(v);
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (idle_off || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // send one request and record its predicted factors on acceptance
  task automatic send_request(input value_t v);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i = 1'b1;
    value_i = v;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    predict_factorization(v);
    @(negedge clk_i);
  endtask

  // compare each strobed result with the oldest predicted one
  always @(posedge clk_i) begin
    factor_rec_t rec;
    if (rst_ni && result_valid_o) begin
      if (expected_factors_q.size() == 0) begin
        $display("%0t: unexpected result factor=%0d is_empty=%0b last=%0b",
                 $time, factor_o, is_empty_o, last_o);
        mismatch_count++;
      end else begin
        rec = expected_factors_q.pop_front();
        if (factor_o !== rec.factor) begin
          $display("%0t: factor expected %0d actual %0d", $time, rec.factor, factor_o);
          mismatch_count++;
        end
        if (is_empty_o !== rec.is_empty) begin
          $display("%0t: is_empty expected %0b actual %0b",
                   $time, rec.is_empty, is_empty_o);
          mismatch_count++;
        end
        if (last_o !== rec.last) begin
          $display("%0t: last expected %0b actual %0b", $time, rec.last, last_o);
          mismatch_count++;
        end
      end
    end
  end

  // product of random small primes, kept inside the field
  function automatic value_t smooth_value();
    int unsigned primes[25] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41,
                                43, 47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97};
    longint      prod;
    longint      q;
    int unsigned n;
    prod = 1;
    n = $urandom_range(1, 40);
    repeat (n) begin
      q = primes[$urandom_range(0, 24)];
      if (prod * q < (64'd1 << ValueBits)) prod = prod * q;
    end
    return value_t'(prod);
  endfunction

  // inputs with no factors
  task automatic test_no_factors();
    send_request(value_t'(0));
    send_request(value_t'(1));
    send_request(value_t'(0));
  endtask

  // small values: exact squares, cofactor left over, repeated divisors
  task automatic test_small_values();
    send_request(value_t'(2));
    send_request(value_t'(3));
    send_request(value_t'(4));
    send_request(value_t'(6));
    send_request(value_t'(25));
    send_request(value_t'(9409));
    send_request(value_t'(1024));
    send_request(value_t'(2 * 1000003));
  endtask

  // field extremes and long runs
  task automatic test_extremes();
    send_request(value_t'(32'h4000_0000));
    send_request(value_t'(32'h3FFF_FFFF));
    send_request(value_t'(32'h7FFF_FFFE));
    send_request(value_t'(1162261467));
    send_request(value_t'(32'h7FFF_FFFF));
    send_request(value_t'(1));
  endtask

  // smooth values, one stretch with no idling
  task automatic test_smooth_values();
    for (int i = 0; i < 50; i++) begin
      idle_off = (i >= 20 && i < 30);
      send_request(smooth_value());
    end
    idle_off = 1'b0;
  endtask

  // small random values, mostly ending with a prime cofactor
  task automatic test_small_random();
    for (int i = 0; i < 25; i++) send_request(value_t'($urandom_range(0, 4095)));
  endtask

  // medium random values, a longer search each
  task automatic test_medium_random();
    for (int i = 0; i < 12; i++) send_request(value_t'($urandom_range(4096, 1 << 18)));
  endtask

  // empty inputs, powers of two and smooth values mixed in back to back
  task automatic test_mixed();
    idle_off = 1'b1;
    for (int i = 0; i < 10; i++) begin
      case ($urandom_range(0, 2))
        0: send_request(value_t'($urandom_range(0, 1)));
        1: send_request(value_t'(1 << $urandom_range(1, ValueBits - 1)));
        default: send_request(smooth_value());
      endcase
    end
    idle_off = 1'b0;
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_no_factors();
    test_small_values();
    test_extremes();
    test_smooth_values();
    test_small_random();
    test_medium_random();
    test_mixed();
    start_i = 1'b0;
    // drain outstanding results, then a short margin
    while (expected_factors_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/tdf_pkg.sv
design/tdf_div.sv
design/trial_division_factorizer.sv
verif/testbench.sv
